// ===== rtl/core/pdot_pkg.sv =====
`timescale 1ns / 1ps
// pdot_pkg: shared types and constants for the periodic deadline overrun tracker
// payload structs, sequencer state codes, operation codes and field widths
// no dependencies
package pdot_pkg;

    localparam int TIME_W = 64;
    localparam int HALF_W = 32;
    localparam int OV_W   = 32;
    localparam int CNT_W  = 32;

    // operation codes
    localparam logic OP_PLAIN = 1'b0;
    localparam logic OP_FIXED = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] now_ticks;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] wakeup_time;
        logic              sleep_needed;
        logic [OV_W-1:0]   overrun_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_CHECK,
        ST_DIV,
        ST_ADJ,
        ST_FIN,
        ST_DONE
    } seq_state_t;

endpackage

// ===== rtl/core/pdot_div.sv =====
`timescale 1ns / 1ps
// pdot_div: bit-serial restoring divider, one quotient bit per cycle
// depends on pdot_pkg for the operand width
module pdot_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pdot_pkg::TIME_W-1:0] dividend,
    input  logic [pdot_pkg::TIME_W-1:0] divisor,
    output logic                       done,
    output logic [pdot_pkg::TIME_W-1:0] quotient,
    output logic [pdot_pkg::TIME_W-1:0] remainder
);
    import pdot_pkg::*;

    localparam int STEP_W = $clog2(TIME_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [TIME_W:0]   partial;
    logic [TIME_W:0]   trial;

    always_comb
    begin
        partial   = {rem_reg, quo_reg[TIME_W-1]};
        trial     = partial - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // borrow clear means the divisor fits
            if (!trial[TIME_W])
            begin
                rem_next = trial[TIME_W-1:0];
            end
            else
            begin
                rem_next = partial[TIME_W-1:0];
            end
            quo_next  = {quo_reg[TIME_W-2:0], ~trial[TIME_W]};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/periodic_deadline_overrun_tracker_top.sv =====
`timescale 1ns / 1ps
// periodic_deadline_overrun_tracker_top: periodic deadline tracker with overrun count
// depends on pdot_pkg and pdot_div
//
// Each input transfer is a wait request carrying the current tick time. The first
// wait after reset or after a period write seeds the deadline from now; every wait
// then moves the deadline on by one period. A plain wait reports whether a sleep is
// needed; a fixed-rate wait that finds its deadline already passed skips ahead by
// ceil(lateness / period) periods and reports that count, saturated to 32 bits.
// Periods below 2^SHORT_PERIOD_SHIFT use wrapping 32-bit time with signed compares,
// longer ones plain 64-bit time; a period of zero acts as one. One request is worked
// at a time: idle, advance, check, then done loads the output register when the last
// result is claimed; a late fixed-rate wait adds divide (64 single-bit steps of the
// shared serial divider), adjust and finish. No new request is taken before done; the
// output register holds the result for the consumer while the block goes back to
// idle and takes the next request. The period register is written via cfg_wr_en /
// cfg_wr_data; the user keeps that to while the block is idle, unenforced.
module periodic_deadline_overrun_tracker_top #(
    parameter int SHORT_PERIOD_SHIFT = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [pdot_pkg::TIME_W-1:0]   cfg_wr_data,
    // wait requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pdot_pkg::in_item_t            in_data,
    // results
    output logic                          out_valid,
    input  logic                          out_ready,
    output pdot_pkg::out_item_t           out_data
);
    import pdot_pkg::*;

    // architectural state
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] deadline_reg;
    logic [CNT_W-1:0]  wait_cnt_reg;

    // sequencer
    seq_state_t state_reg, state_next;

    // working registers for the request in flight
    in_item_t          req_reg;
    logic [TIME_W-1:0] per_reg;
    logic              short_reg;
    logic [TIME_W-1:0] dl_reg;
    logic              sleep_reg;
    logic [OV_W-1:0]   ov_reg;
    logic [TIME_W-1:0] adj_reg;

    // output register
    out_item_t         out_reg;
    logic              out_valid_reg;

    // control strobes
    logic in_xfer;
    logic div_start;
    logic out_load;

    // datapath terms
    logic [TIME_W-1:0] per_eff;
    logic              short_eff;
    logic [TIME_W-1:0] base_time;
    logic [HALF_W-1:0] dl_short;
    logic [TIME_W-1:0] dl_long;
    logic [TIME_W:0]   late_full;
    logic [HALF_W-1:0] late32;
    logic [HALF_W-1:0] ahead32;
    logic              check_sleep;
    logic              go_div;
    logic [TIME_W-1:0] div_dividend;
    logic              div_done;
    logic [TIME_W-1:0] div_quo;
    logic [TIME_W-1:0] div_rem;
    logic              rem_nz;
    logic [TIME_W-1:0] ov_full;
    logic [TIME_W-1:0] dl_fixed;

    // shared serial divider
    pdot_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (per_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // advance step: effective period, time domain and deadline plus one period
    always_comb
    begin
        per_eff   = (period_reg == '0) ? TIME_W'(1) : period_reg;
        short_eff = ~|per_eff[TIME_W-1:SHORT_PERIOD_SHIFT];
        base_time = (wait_cnt_reg == '0) ? req_reg.now_ticks : deadline_reg;
        dl_short  = base_time[HALF_W-1:0] + per_eff[HALF_W-1:0];
        dl_long   = base_time + per_eff;
    end

    // check step: lateness in both domains and the catch-up decision
    always_comb
    begin
        late_full    = {1'b0, req_reg.now_ticks} - {1'b0, dl_reg};
        late32       = req_reg.now_ticks[HALF_W-1:0] - dl_reg[HALF_W-1:0];
        ahead32      = dl_reg[HALF_W-1:0] - req_reg.now_ticks[HALF_W-1:0];
        check_sleep  = 1'b1;
        go_div       = 1'b0;
        div_dividend = late_full[TIME_W-1:0];
        if (short_reg)
        begin
            div_dividend = {{(TIME_W-HALF_W){1'b0}}, late32};
            if (req_reg.operation == OP_PLAIN)
            begin
                // sleep only while the deadline is strictly ahead in signed time
                check_sleep = (late32 != '0) && !ahead32[HALF_W-1];
            end
            else
            begin
                check_sleep = (late32 != '0);
                go_div      = (late32 != '0) && !late32[HALF_W-1];
            end
        end
        else if (req_reg.operation == OP_FIXED)
        begin
            check_sleep = (late_full[TIME_W-1:0] != '0);
            go_div      = !late_full[TIME_W] && (late_full[TIME_W-1:0] != '0);
        end
    end

    // catch-up: ceil count and deadline = now + (period - rem) when rem is nonzero
    always_comb
    begin
        rem_nz   = (div_rem != '0);
        ov_full  = div_quo + {{(TIME_W-1){1'b0}}, rem_nz};
        dl_fixed = req_reg.now_ticks + adj_reg;
    end

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = go_div ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait here only while the previous result is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output / strobe logic
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready  = 1'b1;
            ST_CHECK: div_start = go_div;
            ST_DONE:  out_load  = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_xfer = in_valid && in_ready;

    // control state and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            period_reg    <= TIME_W'(1);
            deadline_reg  <= '0;
            wait_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                deadline_reg  <= dl_reg;
                wait_cnt_reg  <= wait_cnt_reg + 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // a period write restarts the wait count
            if (cfg_wr_en)
            begin
                period_reg   <= cfg_wr_data;
                wait_cnt_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg <= in_data;
        end
        unique case (state_reg)
            ST_ADV:
            begin
                per_reg   <= per_eff;
                short_reg <= short_eff;
                dl_reg    <= short_eff ? {{(TIME_W-HALF_W){1'b0}}, dl_short} : dl_long;
            end
            ST_CHECK:
            begin
                sleep_reg <= check_sleep;
                ov_reg    <= '0;
            end
            ST_ADJ:
            begin
                adj_reg <= rem_nz ? (per_reg - div_rem) : '0;
                ov_reg  <= (|ov_full[TIME_W-1:OV_W]) ? {OV_W{1'b1}} : ov_full[OV_W-1:0];
            end
            ST_FIN:
            begin
                dl_reg <= short_reg ? {{(TIME_W-HALF_W){1'b0}}, dl_fixed[HALF_W-1:0]}
                                    : dl_fixed;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_reg.wakeup_time   <= dl_reg;
            out_reg.sleep_needed  <= sleep_reg;
            out_reg.overrun_count <= ov_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== tb/periodic_deadline_overrun_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// periodic_deadline_overrun_tracker_top_tb: self-checking bench for the deadline tracker
// drives wait requests through valid/ready, predicts each result and compares field by field
// depends on pdot_pkg and periodic_deadline_overrun_tracker_top
module periodic_deadline_overrun_tracker_top_tb;

    import pdot_pkg::*;

    localparam int PERIOD_SHIFT  = 31;
    localparam int RANDOM_ITEMS  = 750;
    // settling time after drain, sized to cover a late fixed-rate wait
    localparam int SETTLE_CYCLES = 80;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;

    // tracker state as the predictor keeps it
    typedef struct {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] deadline;
        logic [CNT_W-1:0]  waits;
    } tracker_state_t;

    logic      clk;
    logic      rst_n       = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic [TIME_W-1:0] cfg_wr_data = '0;
    logic      in_valid    = 1'b0;
    logic      in_ready;
    in_item_t  in_data     = '0;
    logic      out_valid;
    logic      out_ready   = 1'b0;
    out_item_t out_data;

    // pending requests, and the results they must produce in order
    in_item_t  wait_requests[$];
    out_item_t expected_wakeups[$];

    // plan_state follows the requests as they are queued, track_state as they transfer
    tracker_state_t plan_state;
    tracker_state_t track_state;

    out_item_t want;
    int        errors       = 0;
    int        quiet_cycles = 0;
    bit        in_xfer      = 1'b0;
    bit        out_xfer     = 1'b0;
    int        tx_gap       = 0;
    bit        tx_burst     = 1'b0;
    int        rx_stall     = 0;
    bit        rx_burst     = 1'b0;
    bit        hold_request = 1'b0;
    bit        hold_started = 1'b0;
    int        hold_left    = 0;

    periodic_deadline_overrun_tracker_top #(
        .SHORT_PERIOD_SHIFT(PERIOD_SHIFT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one wait: seed on the first wait after a period write, step by one period,
    // then either report sleep (plain) or skip the missed periods (fixed rate)
    function automatic out_item_t advance_deadline(inout tracker_state_t s, input in_item_t req);
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] lag;
        logic [TIME_W-1:0] skipped;
        logic [HALF_W-1:0] now32;
        logic [HALF_W-1:0] dl32;
        logic [HALF_W-1:0] lag32;
        logic [HALF_W-1:0] ahead32;
        logic              sleep;
        out_item_t         r;
        per     = (s.period == '0) ? 64'd1 : s.period;
        skipped = '0;
        sleep   = 1'b1;
        if ((per >> PERIOD_SHIFT) == '0)
        begin
            // short period: wrapping 32-bit time, signed compares
            now32 = req.now_ticks[HALF_W-1:0];
            dl32  = (s.waits == '0) ? now32 : s.deadline[HALF_W-1:0];
            dl32  = dl32 + per[HALF_W-1:0];
            if (req.operation == OP_PLAIN)
            begin
                ahead32 = dl32 - now32;
                sleep   = (ahead32 != '0) && !ahead32[HALF_W-1];
            end
            else
            begin
                lag32 = now32 - dl32;
                sleep = (lag32 != '0);
                // a lag past half the range counts as early, no catch-up
                if (lag32 != '0 && !lag32[HALF_W-1])
                begin
                    skipped = ({32'd0, lag32} + per - 64'd1) / per;
                    dl32    = dl32 + HALF_W'(skipped * per);
                end
            end
            s.deadline = {32'd0, dl32};
        end
        else
        begin
            // long period: plain unsigned 64-bit time
            dl = (s.waits == '0) ? req.now_ticks : s.deadline;
            dl = dl + per;
            if (req.operation == OP_FIXED)
            begin
                if (dl == req.now_ticks)
                    sleep = 1'b0;
                else if (dl < req.now_ticks)
                begin
                    lag     = req.now_ticks - dl;
                    skipped = lag / per + (((lag % per) != '0) ? 64'd1 : 64'd0);
                    dl      = dl + skipped * per;
                end
            end
            s.deadline = dl;
        end
        s.waits           = s.waits + 1'b1;
        r.wakeup_time     = s.deadline;
        r.sleep_needed    = sleep;
        r.overrun_count   = (skipped > 64'hFFFF_FFFF) ? '1 : skipped[OV_W-1:0];
        return r;
    endfunction

    // sampling at the rising edge: transfers, prediction, result check, watchdog
    always @(posedge clk)
    begin
        in_xfer  = in_valid && in_ready;
        out_xfer = out_valid && out_ready;
        if (in_xfer)
            expected_wakeups.push_back(advance_deadline(track_state, in_data));
        if (out_xfer)
        begin
            if (expected_wakeups.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_wakeups.pop_front();
                if (out_data.wakeup_time !== want.wakeup_time)
                begin
                    $display("%0t: wakeup_time expected %h actual %h",
                             $time, want.wakeup_time, out_data.wakeup_time);
                    errors++;
                end
                if (out_data.sleep_needed !== want.sleep_needed)
                begin
                    $display("%0t: sleep_needed expected %b actual %b",
                             $time, want.sleep_needed, out_data.sleep_needed);
                    errors++;
                end
                if (out_data.overrun_count !== want.overrun_count)
                begin
                    $display("%0t: overrun_count expected %h actual %h",
                             $time, want.overrun_count, out_data.overrun_count);
                    errors++;
                end
            end
        end
        // nothing moving for this long means the block hung
        quiet_cycles = (in_xfer || out_xfer) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // request driver: a random gap after each transfer, with bursts of back-to-back requests
    always @(negedge clk)
    begin
        if (!in_valid || in_xfer)
        begin
            if (tx_gap > 0)
            begin
                in_valid <= 1'b0;
                tx_gap = tx_gap - 1;
            end
            else if (wait_requests.size() > 0)
            begin
                in_data  <= wait_requests.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: a random stall per result, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (out_xfer)
        begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            rx_stall = rx_burst ? 0 : $urandom_range(0, 17);
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall = rx_stall - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // wait until every queued request has transferred and every result has come back
    task automatic drain();
        while (wait_requests.size() != 0 || in_valid || expected_wakeups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // period write while idle; restarts the wait count on both state copies
    task automatic write_period(input logic [TIME_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        plan_state.period  = value;
        plan_state.waits   = '0;
        track_state.period = value;
        track_state.waits  = '0;
    endtask

    task automatic queue_wait(input logic op, input logic [TIME_W-1:0] now);
        in_item_t req;
        req.operation = op;
        req.now_ticks = now;
        wait_requests.push_back(req);
        void'(advance_deadline(plan_state, req));
    endtask

    // pick a tick time around the next deadline: on time, early, late, far late, or anywhere
    function automatic logic [TIME_W-1:0] pick_now();
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] target;
        logic [TIME_W-1:0] off;
        logic [TIME_W-1:0] now;
        int                c;
        per    = (plan_state.period == '0) ? 64'd1 : plan_state.period;
        target = plan_state.deadline + per;
        off    = $urandom_range(0, 1) ? 64'($urandom_range(1, 50))
                                       : (per >> $urandom_range(0, 8)) + 64'd1;
        c      = $urandom_range(0, 99);
        if (plan_state.waits == '0 || c >= 90)
            now = {$urandom(), $urandom()};
        else if (c < 25)
            now = target;
        else if (c < 45)
            now = target - off;
        else if (c < 65)
            now = target + off;
        else if (c < 82)
            now = target + per * 64'($urandom_range(1, 6)) + 64'($urandom_range(0, 2)) - 64'd1;
        else
            now = target + 64'h8000_0000 + off;
        // short periods ignore the upper half of time, so let it wander
        if ((per >> PERIOD_SHIFT) == '0 && $urandom_range(0, 1))
            now[TIME_W-1:HALF_W] = $urandom();
        return now;
    endfunction

    function automatic logic [TIME_W-1:0] pick_period(input int kind);
        case (kind)
            0: return 64'd0;
            1: return 64'd1;
            2: return 64'($urandom_range(1, 100));
            3: return 64'($urandom_range(1, 1000000));
            4: return 64'($urandom_range(1, 32'h7FFF_FFFF));
            5: return 64'h8000_0000;
            6: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return {$urandom(), $urandom()} | (64'h8000_0000 << $urandom_range(0, 32));
        endcase
    endfunction

    initial
    begin
        int sent;
        int ph;
        int count;
        plan_state  = '{period: 64'd1, deadline: '0, waits: '0};
        track_state = plan_state;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short period: seed, plain on time, fixed on time, catch-up,
        // exact multiple, lag past half range, wrap of 32-bit time
        write_period(64'd100);
        queue_wait(OP_PLAIN, 64'd1000);
        queue_wait(OP_PLAIN, 64'd1200);
        queue_wait(OP_FIXED, 64'hA5A5_5A5A_0000_0514);
        queue_wait(OP_FIXED, 64'd1650);
        queue_wait(OP_FIXED, 64'd1900);
        queue_wait(OP_FIXED, 64'd2000 + 64'h8000_0005);
        queue_wait(OP_PLAIN, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_wait(OP_FIXED, 64'd0);
        drain();

        // zero period behaves as one
        write_period(64'd0);
        queue_wait(OP_PLAIN, 64'd0);
        queue_wait(OP_FIXED, 64'd5);
        queue_wait(OP_FIXED, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // largest short period, deadline wrapping past 2^32
        write_period(64'h7FFF_FFFF);
        queue_wait(OP_PLAIN, 64'h0000_0000_FFFF_FFF0);
        queue_wait(OP_FIXED, 64'h0000_0001_7FFF_FFEF);
        queue_wait(OP_FIXED, 64'h5555_0000_FFFF_FFFF);
        drain();

        // smallest long period: on time, then an overrun count that saturates
        write_period(64'h8000_0000);
        queue_wait(OP_PLAIN, 64'd0);
        queue_wait(OP_FIXED, 64'h0000_0001_0000_0000);
        queue_wait(OP_FIXED, 64'h8000_0001_8000_0000);
        queue_wait(OP_PLAIN, 64'd0);
        drain();

        // largest period, deadline wrapping past 2^64
        write_period(64'hFFFF_FFFF_FFFF_FFFF);
        queue_wait(OP_PLAIN, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_wait(OP_FIXED, 64'd0);
        queue_wait(OP_FIXED, 64'hFFFF_FFFF_FFFF_FFFC);
        queue_wait(OP_PLAIN, 64'h7FFF_FFFF_FFFF_FFFF);
        drain();

        // random phases: every period kind once, then random kinds
        sent = 0;
        ph   = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_period(pick_period((ph < 8) ? ph : $urandom_range(0, 7)));
            count = $urandom_range(30, 90);
            repeat (count)
                queue_wait($urandom_range(0, 1) ? OP_FIXED : OP_PLAIN, pick_now());
            // receiver stops for a long stretch while requests keep coming
            if (ph == 2)
                hold_request = 1'b1;
            sent += count;
            ph++;
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== periodic_deadline_overrun_tracker_top.f =====
rtl/core/pdot_pkg.sv
rtl/core/pdot_div.sv
rtl/core/periodic_deadline_overrun_tracker_top.sv
tb/periodic_deadline_overrun_tracker_top_tb.sv
